@@ rtl/core/ubds_pkg.sv @@
// Package for the UART baud divisor selector: widths, constants, register map.
// No dependencies.
`timescale 1ns / 1ps

package ubds_pkg;

  localparam int CLK_W     = 27;
  localparam int BAUD_W    = 22;
  localparam int DIVISOR_W = 16;
  localparam int DIV_W     = 25;  // dividend / quotient width of the pipelined divider
  localparam int ERR_W     = 25;
  localparam int PROD_W    = ERR_W + 10;  // error scaled by 1000
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(40000000);
  localparam int ERR_SCALE = 1000;
  localparam int ERR_LIMIT = 25;

  // Register index of cycle_clock_hz (byte address 4*index).
  localparam logic [PADDR_W-3:0] REG_CLK = '0;

endpackage

@@ rtl/core/ubds_in_if.sv @@
// Request channel of the baud divisor selector: valid/ready plus baud_rate.
// Depends on ubds_pkg.
`timescale 1ns / 1ps

interface ubds_in_if;
  import ubds_pkg::*;

  logic              valid;
  logic              ready;
  logic [BAUD_W-1:0] baud_rate;

  modport source (output valid, output baud_rate, input ready);
  modport sink   (input valid, input baud_rate, output ready);
endinterface

@@ rtl/core/ubds_out_if.sv @@
// Result channel of the baud divisor selector: valid/ready plus divisor and flags.
// Depends on ubds_pkg.
`timescale 1ns / 1ps

interface ubds_out_if;
  import ubds_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DIVISOR_W-1:0] divisor;
  logic                 high_speed;
  logic                 zero_rate;

  modport source (output valid, output divisor, output high_speed, output zero_rate,
                  input ready);
  modport sink   (input valid, input divisor, input high_speed, input zero_rate,
                  output ready);
endinterface

@@ rtl/core/ubds_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, DIV_W stages.
// Depends on ubds_pkg. Advances only when en is high.
`timescale 1ns / 1ps

module ubds_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ubds_pkg::DIV_W-1:0]  num_in,
  input  logic [ubds_pkg::BAUD_W-1:0] den_in,
  output logic [ubds_pkg::DIV_W-1:0]  quo_out
);
  import ubds_pkg::*;

  logic [DIV_W-1:0]  num_r [1:DIV_W-1];
  logic [BAUD_W-1:0] den_r [1:DIV_W-1];
  logic [BAUD_W-1:0] rem_r [1:DIV_W-1];
  logic [DIV_W-1:0]  quo_r [1:DIV_W];

  for (genvar s = 0; s < DIV_W; s++) begin : g_stage
    logic [DIV_W-1:0]  num_p;
    logic [BAUD_W-1:0] den_p;
    logic [BAUD_W-1:0] rem_p;
    logic [DIV_W-1:0]  quo_p;
    logic [BAUD_W:0]   trial;
    logic [BAUD_W:0]   diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign num_p = num_in;
      assign den_p = den_in;
      assign rem_p = '0;
      assign quo_p = '0;
    end else begin : g_rest
      assign num_p = num_r[s];
      assign den_p = den_r[s];
      assign rem_p = rem_r[s];
      assign quo_p = quo_r[s];
    end

    assign trial = {rem_p, num_p[DIV_W-1-s]};
    assign diff  = trial - {1'b0, den_p};
    assign ge    = trial >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s+1] <= {quo_p[DIV_W-2:0], ge};
      end
    end

    // last stage only hands on the quotient
    if (s < DIV_W-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          num_r[s+1] <= num_p;
          den_r[s+1] <= den_p;
          rem_r[s+1] <= ge ? diff[BAUD_W-1:0] : trial[BAUD_W-1:0];
        end
      end
    end
  end

  assign quo_out = quo_r[DIV_W];

endmodule

@@ rtl/core/uart_baud_divisor_select.sv @@
// Path of a request word: input register, divider bank one, p1, bank two, p2, output.
// Throughput: one word per cycle; two chains of 25-stage bit-per-stage dividers set
// the depth. The whole pipeline holds when the output register is full and not taken.
// Reset (rst, synchronous): all valid bits clear, cycle_clock_hz returns to 40000000.
// Depends on ubds_pkg, ubds_in_if, ubds_out_if, ubds_div.
`timescale 1ns / 1ps

module uart_baud_divisor_select (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ubds_pkg::PADDR_W-1:0] paddr,
  input  logic [ubds_pkg::PDATA_W-1:0] pwdata,
  output logic [ubds_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  ubds_in_if.sink                      in_ch,
  ubds_out_if.source                   out_ch
);
  import ubds_pkg::*;

  typedef struct packed {
    logic              valid;
    logic              zero;
    logic [BAUD_W-1:0] baud;
  } sb_a_t;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic [BAUD_W-1:0]    baud;
    logic [DIVISOR_W-1:0] c16_lo;
    logic [DIVISOR_W-1:0] c16_hi;
    logic [DIVISOR_W-1:0] c4_lo;
    logic [DIVISOR_W-1:0] c4_hi;
  } sb_b_t;

  // Config register
  logic [CLK_W-1:0] cycle_clock_hz;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[PADDR_W-1:2] == REG_CLK;
  assign prdata  = reg_hit ? PDATA_W'(cycle_clock_hz) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_clock_hz <= CLK_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      cycle_clock_hz <= pwdata[CLK_W-1:0];
    end
  end

  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  logic [DIV_W-1:0] clk_div16;
  logic [DIV_W-1:0] clk_div4;
  assign clk_div16 = DIV_W'(cycle_clock_hz >> 4);
  assign clk_div4  = DIV_W'(cycle_clock_hz >> 2);

  // Input register
  sb_a_t p0;
  always_ff @(posedge clk) begin
    if (rst) begin
      p0.valid <= 1'b0;
    end else if (en) begin
      p0.valid <= in_ch.valid;
    end
    if (en) begin
      p0.zero <= in_ch.baud_rate == '0;
      p0.baud <= in_ch.baud_rate;
    end
  end

  // First divider bank: clk/(k*baud)
  logic [DIV_W-1:0] q16;
  logic [DIV_W-1:0] q4;

  ubds_div u_div_q16 (.clk(clk), .en(en), .num_in(clk_div16), .den_in(p0.baud),
                      .quo_out(q16));
  ubds_div u_div_q4  (.clk(clk), .en(en), .num_in(clk_div4),  .den_in(p0.baud),
                      .quo_out(q4));

  sb_a_t sb_a [DIV_W];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_W; i++) sb_a[i].valid <= 1'b0;
    end else if (en) begin
      sb_a[0].valid <= p0.valid;
      for (int i = 1; i < DIV_W; i++) sb_a[i].valid <= sb_a[i-1].valid;
    end
    if (en) begin
      sb_a[0].zero <= p0.zero;
      sb_a[0].baud <= p0.baud;
      for (int i = 1; i < DIV_W; i++) begin
        sb_a[i].zero <= sb_a[i-1].zero;
        sb_a[i].baud <= sb_a[i-1].baud;
      end
    end
  end

  // Candidates d and d+1 (16-bit wrap), and their divisors c+1 (1..65536)
  logic [DIVISOR_W-1:0] c16_lo_c, c16_hi_c, c4_lo_c, c4_hi_c;
  assign c16_lo_c = DIVISOR_W'(q16 - 1'b1);
  assign c16_hi_c = c16_lo_c + 1'b1;
  assign c4_lo_c  = DIVISOR_W'(q4 - 1'b1);
  assign c4_hi_c  = c4_lo_c + 1'b1;

  sb_b_t p1;
  always_ff @(posedge clk) begin
    if (rst) begin
      p1.valid <= 1'b0;
    end else if (en) begin
      p1.valid <= sb_a[DIV_W-1].valid;
    end
    if (en) begin
      p1.zero   <= sb_a[DIV_W-1].zero;
      p1.baud   <= sb_a[DIV_W-1].baud;
      p1.c16_lo <= c16_lo_c;
      p1.c16_hi <= c16_hi_c;
      p1.c4_lo  <= c4_lo_c;
      p1.c4_hi  <= c4_hi_c;
    end
  end

  logic [BAUD_W-1:0] m16_lo, m16_hi, m4_lo, m4_hi;
  assign m16_lo = BAUD_W'(p1.c16_lo) + 1'b1;
  assign m16_hi = BAUD_W'(p1.c16_hi) + 1'b1;
  assign m4_lo  = BAUD_W'(p1.c4_lo) + 1'b1;
  assign m4_hi  = BAUD_W'(p1.c4_hi) + 1'b1;

  // Second divider bank: actual rates
  logic [DIV_W-1:0] r16_lo, r16_hi, r4_lo, r4_hi;

  ubds_div u_div_r16_lo (.clk(clk), .en(en), .num_in(clk_div16), .den_in(m16_lo),
                         .quo_out(r16_lo));
  ubds_div u_div_r16_hi (.clk(clk), .en(en), .num_in(clk_div16), .den_in(m16_hi),
                         .quo_out(r16_hi));
  ubds_div u_div_r4_lo  (.clk(clk), .en(en), .num_in(clk_div4),  .den_in(m4_lo),
                         .quo_out(r4_lo));
  ubds_div u_div_r4_hi  (.clk(clk), .en(en), .num_in(clk_div4),  .den_in(m4_hi),
                         .quo_out(r4_hi));

  sb_b_t sb_b [DIV_W];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_W; i++) sb_b[i].valid <= 1'b0;
    end else if (en) begin
      sb_b[0].valid <= p1.valid;
      for (int i = 1; i < DIV_W; i++) sb_b[i].valid <= sb_b[i-1].valid;
    end
    if (en) begin
      sb_b[0].zero   <= p1.zero;
      sb_b[0].baud   <= p1.baud;
      sb_b[0].c16_lo <= p1.c16_lo;
      sb_b[0].c16_hi <= p1.c16_hi;
      sb_b[0].c4_lo  <= p1.c4_lo;
      sb_b[0].c4_hi  <= p1.c4_hi;
      for (int i = 1; i < DIV_W; i++) begin
        sb_b[i].zero   <= sb_b[i-1].zero;
        sb_b[i].baud   <= sb_b[i-1].baud;
        sb_b[i].c16_lo <= sb_b[i-1].c16_lo;
        sb_b[i].c16_hi <= sb_b[i-1].c16_hi;
        sb_b[i].c4_lo  <= sb_b[i-1].c4_lo;
        sb_b[i].c4_hi  <= sb_b[i-1].c4_hi;
      end
    end
  end

  // Errors and per-prescaler pick; tie goes to d+1
  sb_b_t             sb_e;
  logic [ERR_W-1:0]  baud_x;
  logic [ERR_W-1:0]  e16_lo, e16_hi, e4_lo, e4_hi;

  assign sb_e   = sb_b[DIV_W-1];
  assign baud_x = ERR_W'(sb_e.baud);
  assign e16_lo = (r16_lo > baud_x) ? r16_lo - baud_x : baud_x - r16_lo;
  assign e16_hi = (r16_hi > baud_x) ? r16_hi - baud_x : baud_x - r16_hi;
  assign e4_lo  = (r4_lo > baud_x)  ? r4_lo - baud_x  : baud_x - r4_lo;
  assign e4_hi  = (r4_hi > baud_x)  ? r4_hi - baud_x  : baud_x - r4_hi;

  logic                 p2_valid;
  logic                 p2_zero;
  logic [BAUD_W-1:0]    p2_baud;
  logic [DIVISOR_W-1:0] p2_div16, p2_div4;
  logic [ERR_W-1:0]     p2_err16;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= sb_e.valid;
    end
    if (en) begin
      p2_zero  <= sb_e.zero;
      p2_baud  <= sb_e.baud;
      p2_div16 <= (e16_lo < e16_hi) ? sb_e.c16_lo : sb_e.c16_hi;
      p2_err16 <= (e16_lo < e16_hi) ? e16_lo : e16_hi;
      p2_div4  <= (e4_lo < e4_hi) ? sb_e.c4_lo : sb_e.c4_hi;
    end
  end

  // err*1000/baud > 25  <=>  err*1000 >= 26*baud
  logic [PROD_W-1:0] err_scaled;
  logic [PROD_W-1:0] baud_scaled;
  logic              go_fast;

  assign err_scaled  = PROD_W'(p2_err16) * PROD_W'(ERR_SCALE);
  assign baud_scaled = PROD_W'(p2_baud) * PROD_W'(ERR_LIMIT + 1);
  assign go_fast     = err_scaled >= baud_scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= p2_valid;
    end
    if (en) begin
      if (p2_zero) begin
        out_ch.divisor    <= '0;
        out_ch.high_speed <= 1'b0;
        out_ch.zero_rate  <= 1'b1;
      end else begin
        out_ch.divisor    <= go_fast ? p2_div4 : p2_div16;
        out_ch.high_speed <= go_fast;
        out_ch.zero_rate  <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/ubds_chk.sv @@
// Port-level checker for uart_baud_divisor_select, bound to the top level.
// Depends on ubds_pkg.
`timescale 1ns / 1ps

module ubds_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [ubds_pkg::DIVISOR_W-1:0] divisor,
  input logic                           high_speed,
  input logic                           zero_rate
);
  import ubds_pkg::*;

  // Input side only stalls while a result word sits untaken
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in ready does not follow output stall");

  // A zero-rate result carries divisor 0 in divide-by-16 mode
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_rate) |-> (divisor == '0 && !high_speed))
    else $error("zero rate result not cleared");

  // No result word right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(divisor) &&
                                   $stable(high_speed) && $stable(zero_rate)))
    else $error("stalled result word changed");

endmodule

bind uart_baud_divisor_select ubds_chk u_ubds_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .divisor    (out_ch.divisor),
  .high_speed (out_ch.high_speed),
  .zero_rate  (out_ch.zero_rate)
);

@@ sim/uart_baud_divisor_select_test.sv @@
// Testbench for uart_baud_divisor_select: directed table, then random baud requests
// under several clock settings, checked against a local divisor predictor.
// Depends on ubds_pkg, ubds_in_if, ubds_out_if and the RTL of the block.
`timescale 1ns / 1ps

module uart_baud_divisor_select_test;
  import ubds_pkg::*;

  localparam int LATENCY = 53;

  typedef struct packed {
    logic [DIVISOR_W-1:0] divisor;
    logic                 high_speed;
    logic                 zero_rate;
  } divisor_word_t;

  typedef struct {
    logic [BAUD_W-1:0] baud;
    bit                typed;  // expected word given in the row
    divisor_word_t     word;
  } baud_row_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  ubds_in_if  in_ch ();
  ubds_out_if out_ch ();

  uart_baud_divisor_select DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  logic [CLK_W-1:0] cycle_hz = CLK_RESET;
  divisor_word_t    pending_divisors[$];
  divisor_word_t    row_words[$];
  bit               row_typed[$];
  int errors = 0, words_in = 0, words_out = 0, hs_count = 0, zero_count = 0;
  bit quiet = 0, hold_req = 0;

  // Better of d and d+1 for prescaler k; wide math throughout.
  function automatic logic [DIVISOR_W-1:0] best_candidate(
      input logic [63:0] hz, input logic [63:0] baud, input logic [63:0] k,
      output logic [63:0] err);
    logic [DIVISOR_W-1:0] c1, c2;
    logic [63:0] r1, r2, e1, e2;
    c1 = DIVISOR_W'(hz / (k * baud) - 1);
    c2 = c1 + 1'b1;
    r1 = hz / (k * (64'(c1) + 1));
    r2 = hz / (k * (64'(c2) + 1));
    e1 = (r1 > baud) ? r1 - baud : baud - r1;
    e2 = (r2 > baud) ? r2 - baud : baud - r2;
    if (e1 < e2) begin
      err = e1;
      return c1;
    end
    err = e2;
    return c2;
  endfunction

  function automatic divisor_word_t predict_divisor(input logic [CLK_W-1:0] hz,
                                                    input logic [BAUD_W-1:0] baud);
    divisor_word_t w;
    logic [63:0] err;
    w = '0;
    if (baud == 0) begin
      w.zero_rate = 1'b1;
      return w;
    end
    w.divisor = best_candidate(64'(hz), 64'(baud), 64'd16, err);
    if (err * ERR_SCALE / baud > ERR_LIMIT) begin
      w.divisor = best_candidate(64'(hz), 64'(baud), 64'd4, err);
      w.high_speed = 1'b1;
    end
    return w;
  endfunction

  // Input monitor: every accepted word gets its expectation.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      divisor_word_t w;
      w = predict_divisor(cycle_hz, in_ch.baud_rate);
      if (row_typed.size() > 0) begin
        if (row_typed.pop_front()) begin
          w = row_words.pop_front();
        end else begin
          void'(row_words.pop_front());
        end
      end
      pending_divisors.push_back(w);
      words_in++;
    end
  end

  // Output checker.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      divisor_word_t got, want;
      got = '{out_ch.divisor, out_ch.high_speed, out_ch.zero_rate};
      words_out++;
      if (got.high_speed) hs_count++;
      if (got.zero_rate) zero_count++;
      if (pending_divisors.size() == 0) begin
        $display("%0t: unexpected word divisor=%0d hs=%0b zr=%0b", $time,
                 got.divisor, got.high_speed, got.zero_rate);
        errors++;
      end else begin
        want = pending_divisors.pop_front();
        if (got.divisor !== want.divisor) begin
          $display("%0t: divisor expected %0d actual %0d", $time, want.divisor, got.divisor);
          errors++;
        end
        if (got.high_speed !== want.high_speed) begin
          $display("%0t: high_speed expected %0b actual %0b", $time,
                   want.high_speed, got.high_speed);
          errors++;
        end
        if (got.zero_rate !== want.zero_rate) begin
          $display("%0t: zero_rate expected %0b actual %0b", $time,
                   want.zero_rate, got.zero_rate);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    out_ch.ready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 0;
        for (n = 0; n < 300; n++) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_baud(input logic [BAUD_W-1:0] b);
    in_ch.valid <= 1;
    in_ch.baud_rate <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_ch.valid <= 0;
    while (pending_divisors.size() > 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] v);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= addr;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    if (addr[PADDR_W-1:2] == REG_CLK) cycle_hz = v[CLK_W-1:0];
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  // Read back cycle_clock_hz and compare with the expected setting.
  task automatic check_clk_reg;
    psel <= 1;
    pwrite <= 0;
    penable <= 0;
    paddr <= {REG_CLK, 2'b00};
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(cycle_hz)) begin
      $display("%0t: cycle_clock_hz expected %0d actual %0d", $time, cycle_hz, prdata);
      errors++;
    end
    psel <= 0;
    penable <= 0;
    @(posedge clk);
  endtask

  function automatic logic [BAUD_W-1:0] random_baud;
    int std_rates[10] = '{300, 1200, 2400, 9600, 19200, 38400, 57600, 115200,
                          921600, 3000000};
    case ($urandom_range(0, 9))
      0, 1, 2: return BAUD_W'(std_rates[$urandom_range(0, 9)]);
      3, 4, 5: return BAUD_W'($urandom_range(1, 4000000));
      6:       return BAUD_W'($urandom_range(1, 300));
      7:       return BAUD_W'($urandom());
      8:       return BAUD_W'(cycle_hz / ($urandom_range(0, 1) ? 16 : 4)
                              + $urandom_range(0, 3) - 1);
      default: return BAUD_W'($urandom_range(3900000, 4194303));
    endcase
  endfunction

  baud_row_t directed[] = '{
    '{22'd0,       1'b1, '{16'd0, 1'b0, 1'b1}},
    '{22'd1,       1'b0, '0},
    '{22'd4000000, 1'b0, '0},
    '{22'h3FFFFF,  1'b0, '0},
    '{22'd9600,    1'b0, '0},
    '{22'd115200,  1'b0, '0},
    '{22'd2500000, 1'b0, '0},
    '{22'd2500001, 1'b0, '0},
    '{22'd1611394, 1'b0, '0},
    '{22'd610,     1'b0, '0},
    '{22'd38,      1'b0, '0},
    '{22'd0,       1'b1, '{16'd0, 1'b0, 1'b1}},
    '{22'h2AAAAA,  1'b0, '0},
    '{22'h155555,  1'b0, '0},
    '{22'd1000000, 1'b0, '0}
  };

  logic [PDATA_W-1:0] clk_settings[] = '{32'd1, 32'h7FFFFFF, 32'd100000000, 32'd0,
                                         32'd16000000, 32'd0, 32'd0, 32'd0};

  initial begin
    int p, i;
    in_ch.valid = 0;
    in_ch.baud_rate = '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset clock first: the directed table.
    check_clk_reg();
    foreach (directed[r]) begin
      row_typed.push_back(directed[r].typed);
      row_words.push_back(directed[r].word);
      send_baud(directed[r].baud);
    end
    for (i = 0; i < 150; i++) send_baud(random_baud());
    drain();

    for (p = 0; p < clk_settings.size(); p++) begin
      logic [PDATA_W-1:0] hz;
      hz = (p >= 5) ? PDATA_W'($urandom_range(1, 100000000)) : clk_settings[p];
      write_reg({REG_CLK, 2'b00}, hz);
      // write to an unmapped index must not disturb the clock
      write_reg(PADDR_W'(4), PDATA_W'($urandom()));
      check_clk_reg();
      quiet = (p == clk_settings.size() - 1);
      if (p == 2) hold_req = 1;
      for (i = 0; i < 175; i++) begin
        send_baud(random_baud());
        if (p != clk_settings.size() - 1 && i % 60 == 0) send_baud('0);
      end
      drain();
    end

    $display("Covered %0d words over %0d clock settings; %0d high-speed, %0d zero-rate.",
             words_out, clk_settings.size() + 1, hs_count, zero_count);
    if (errors == 0 && words_in == words_out) begin
      $display("uart_baud_divisor_select_test OK");
    end else begin
      $display("uart_baud_divisor_select_test NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("%0t: timeout, %0d words still expected", $time, pending_divisors.size());
    $display("uart_baud_divisor_select_test NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ubds_pkg.sv
rtl/core/ubds_in_if.sv
rtl/core/ubds_out_if.sv
rtl/core/ubds_div.sv
rtl/core/uart_baud_divisor_select.sv
rtl/core/ubds_chk.sv
sim/uart_baud_divisor_select_test.sv
